// ===== src/lrg_pkg.sv =====
// ============================================================================
// Linear ramp generator package
// Shared defaults, command codes and sequencer states.
// ============================================================================
package lrg_pkg;

    localparam int VALUE_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 16;

    typedef enum logic {
        CMD_SET  = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } t_state;

endpackage

// ===== src/lrg_divider.sv =====
// ============================================================================
// Linear ramp generator divider
// Restoring divider that produces one quotient bit per cycle. The upper part
// of the dividend must already be below the divisor.
// ============================================================================
module lrg_divider #(
    parameter int VALUE_WIDTH = lrg_pkg::VALUE_WIDTH_DEF,
    parameter int TIME_WIDTH  = lrg_pkg::TIME_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [VALUE_WIDTH+TIME_WIDTH:0]   i_num,
    input  logic [TIME_WIDTH-1:0]             i_den,
    output logic                              o_busy,
    output logic                              o_done,
    output logic [VALUE_WIDTH:0]              o_quo,
    output logic [TIME_WIDTH-1:0]             o_rem
);
    import lrg_pkg::*;

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [TIME_WIDTH-1:0]  r_rem;
    logic [VALUE_WIDTH:0]   r_quo;
    logic [TIME_WIDTH-1:0]  r_den;
    logic [CW-1:0]          r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [TIME_WIDTH:0]    w_trial;
    logic                   w_fit;
    logic [TIME_WIDTH:0]    w_diff;

    assign w_trial = {r_rem, r_quo[VALUE_WIDTH]};
    assign w_fit   = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(VALUE_WIDTH)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[VALUE_WIDTH+TIME_WIDTH:VALUE_WIDTH+1];
            r_quo <= i_num[VALUE_WIDTH:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[TIME_WIDTH-1:0] : w_trial[TIME_WIDTH-1:0];
            r_quo <= {r_quo[VALUE_WIDTH-1:0], w_fit};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== src/linear_ramp_generator_top.sv =====
// ============================================================================
// Linear ramp generator
// Timed ramp from a latched start level to a target over a set duration.
// ============================================================================
// A set word latches the present level as the start, the new target and the
// duration, and goes straight to the done state. A tick word that finds the
// level at the target also goes straight to done, and one that reaches the end
// of the ramp passes through the check state first. A tick inside the ramp
// multiplies the level difference by the elapsed total and divides by the
// duration in a divider that makes one quotient bit per cycle, then sets the
// level in the finish state. One word is processed at a time; the result
// register lets the next word in while the last result waits.
module linear_ramp_generator_top #(
    parameter int VALUE_WIDTH = lrg_pkg::VALUE_WIDTH_DEF,
    parameter int TIME_WIDTH  = lrg_pkg::TIME_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  lrg_pkg::t_cmd                 i_cmd,
    input  logic signed [VALUE_WIDTH-1:0] i_target_value,
    input  logic [TIME_WIDTH-1:0]         i_ramp_time,
    input  logic [TIME_WIDTH-1:0]         i_elapsed,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [VALUE_WIDTH-1:0] o_current_value,
    output logic                          o_changed
);
    import lrg_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int TW = TIME_WIDTH;

    t_state             r_state, n_state;
    logic [VW-1:0]      r_level, n_level;
    logic [VW-1:0]      r_start, n_start;
    logic [VW-1:0]      r_target, n_target;
    logic [TW-1:0]      r_dur, n_dur;
    logic [TW-1:0]      r_total, n_total;
    logic               r_changed, n_changed;
    logic               r_neg, n_neg;
    logic               r_out_valid, n_out_valid;
    logic [VW-1:0]      r_out_value, n_out_value;
    logic               r_out_changed, n_out_changed;

    logic               w_in_acc;
    logic [TW:0]        w_sum;
    logic [VW:0]        w_diff;
    logic [VW:0]        w_mag;
    logic [VW+TW:0]     w_prod;
    logic               w_div_start;
    logic               w_div_busy;
    logic               w_div_done;
    logic [VW:0]        w_quo;
    logic [TW-1:0]      w_rem;
    logic               w_frac;
    logic [VW+1:0]      w_qs;
    logic [VW+1:0]      w_q;
    logic [VW+1:0]      w_base;
    logic [VW+1:0]      w_base_adj;

    assign w_in_acc = i_valid && o_ready;
    assign w_sum    = {1'b0, r_total} + {1'b0, i_elapsed};
    assign w_diff   = {r_target[VW-1], r_target} - {r_start[VW-1], r_start};
    assign w_mag    = w_diff[VW] ? (~w_diff + (VW+1)'(1)) : w_diff;
    assign w_prod   = {{TW{1'b0}}, w_mag} * {{(VW+1){1'b0}}, r_total};

    lrg_divider #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod),
        .i_den   (r_dur),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    assign w_frac     = |w_rem;
    assign w_qs       = {1'b0, w_quo};
    assign w_q        = r_neg ? ((~w_qs + (VW+2)'(1)) - (VW+2)'(w_frac)) : w_qs;
    assign w_base     = {{2{r_start[VW-1]}}, r_start} + w_q;
    assign w_base_adj = (w_base[VW+1] && w_frac) ? (w_base + (VW+2)'(1)) : w_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_level     <= '0;
            r_start     <= '0;
            r_target    <= '0;
            r_dur       <= '0;
            r_total     <= '0;
            r_changed   <= 1'b0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_start     <= n_start;
            r_target    <= n_target;
            r_dur       <= n_dur;
            r_total     <= n_total;
            r_changed   <= n_changed;
            r_neg       <= n_neg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value   <= n_out_value;
        r_out_changed <= n_out_changed;
    end

    always_comb begin
        n_state       = r_state;
        n_level       = r_level;
        n_start       = r_start;
        n_target      = r_target;
        n_dur         = r_dur;
        n_total       = r_total;
        n_changed     = r_changed;
        n_neg         = r_neg;
        n_out_valid   = r_out_valid && !i_ready;
        n_out_value   = r_out_value;
        n_out_changed = r_out_changed;
        w_div_start   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_cmd == CMD_SET) begin
                        n_start   = r_level;
                        n_target  = i_target_value;
                        n_dur     = i_ramp_time;
                        n_total   = '0;
                        n_changed = 1'b0;
                        n_state   = ST_DONE;
                    end else if (r_level == r_target) begin
                        n_changed = 1'b0;
                        n_state   = ST_DONE;
                    end else begin
                        n_total   = w_sum[TW] ? '1 : w_sum[TW-1:0];
                        n_changed = 1'b1;
                        n_state   = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (r_dur <= r_total) begin
                    n_level = r_target;
                    n_state = ST_DONE;
                end else begin
                    w_div_start = 1'b1;
                    n_neg       = w_diff[VW];
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_level = w_base_adj[VW-1:0];
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_value   = r_level;
                    n_out_changed = r_changed;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready         = (r_state == ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_current_value = r_out_value;
    assign o_changed       = r_out_changed;

    a_div_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (w_div_busy || w_div_done))
        else $error("Sequencer waits on an idle divider.");

    a_set_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_cmd == CMD_SET) |=> (r_total == '0 && r_state == ST_DONE))
        else $error("Set word did not clear the elapsed total.");

    a_total_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_in_acc && i_cmd == CMD_SET) |=> (r_total >= $past(r_total)))
        else $error("Elapsed total fell without a set word.");

endmodule
